// ===== hdl/rfcd_pkg.sv =====
package rfcd_pkg;

  // Parse phases of the chunk byte stream
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_SKIP_LO  = 4'd1,
    PH_SKIP_HI  = 4'd2,
    PH_CNT_LO   = 4'd3,
    PH_CNT_HI   = 4'd4,
    PH_SEGCOUNT = 4'd5,
    PH_PIXSKIP  = 4'd6,
    PH_SEGHEAD  = 4'd7,
    PH_RUN      = 4'd8
  } phase_t;

  localparam int unsigned KEY_HEIGHT_RESET = 200;
  localparam logic [15:0] ADDR_MAX = 16'hFFFF;

  // One compressed byte with its chunk flags
  typedef struct packed {
    logic       delta_chunk;
    logic       chunk_start;
    logic [7:0] data_byte;
  } item_t;

  // One frame-buffer write, or an end marker
  typedef struct packed {
    logic        chunk_end;
    logic        beyond_frame;
    logic [7:0]  run_length;
    logic [7:0]  pixel_value;
    logic [15:0] write_address;
  } result_t;

endpackage

// ===== hdl/rle_frame_chunk_decoder.sv =====
// Run-length frame chunk decoder. Takes one compressed chunk byte per request
// on the slave side and gives at most one frame-buffer write per byte on the
// master side: a literal pixel (run_length 1) or a whole fill run (1..128).
// A chunk begins with the byte flagged chunk_start; delta_chunk on that byte
// selects delta format, else key format with cfg_wdata lines (key_height, reset
// 200; the user must write it only while idle, the block does not enforce it).
// The last result of a chunk carries tlast; if the chunk's last byte gives no
// write, a zero-length end marker is sent. Writes that reach past
// LINE_WIDTH*FRAME_HEIGHT carry beyond_frame, and addresses above 65535 read as
// 65535. Throughput is one byte per clock: the byte sits in an input register,
// the parse step is combinational logic, and its result goes to an output
// register, so the stream stalls only under master back-pressure.
module rle_frame_chunk_decoder #(
  parameter int unsigned LINE_WIDTH   = 320,
  parameter int unsigned FRAME_HEIGHT = 200
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,   // key_height
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] data_byte
  input  logic [1:0]  s_tuser,     // [0] chunk_start, [1] delta_chunk
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,     // [15:0] write_address, [23:16] pixel_value,
                                   // [31:24] run_length
  output logic        m_tuser,     // [0] beyond_frame
  output logic        m_tlast      // chunk_end
);
  import rfcd_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.data_byte   = s_tdata;
  assign in_item.chunk_start = s_tuser[0];
  assign in_item.delta_chunk = s_tuser[1];

  assign advance = held_valid && out_free;

  rfcd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  rfcd_parser #(
    .LINE_WIDTH   (LINE_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  rfcd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .load_res  (res),
    .free      (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {out_res.run_length, out_res.pixel_value, out_res.write_address};
  assign m_tuser = out_res.beyond_frame;
  assign m_tlast = out_res.chunk_end;

  // A zero-length result is only ever the end marker
  a_marker_is_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[31:24] == 8'd0 |-> m_tlast && m_tdata[23:0] == 24'd0)
    else $error("zero-length result that is not a clean end marker");

  // Runs never exceed 128 pixels
  a_run_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:24] <= 8'd128)
    else $error("run length above 128");

  // A held byte waits while the output register is blocked
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    held_valid && !out_free |=> held_valid && $stable(held_item))
    else $error("input byte lost during output stall");

endmodule

// ===== hdl/rfcd_in_reg.sv =====
module rfcd_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rfcd_pkg::item_t in_item,
  input  logic           advance,
  output logic           held_valid,
  output rfcd_pkg::item_t held_item
);
  import rfcd_pkg::*;

  // Free when empty or when the held byte is parsed this cycle
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== hdl/rfcd_parser.sv =====
module rfcd_parser #(
  parameter int unsigned LINE_WIDTH   = 320,
  parameter int unsigned FRAME_HEIGHT = 200
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [7:0]        cfg_wdata,
  input  logic              step,
  input  rfcd_pkg::item_t   item,
  output logic              res_valid,
  output rfcd_pkg::result_t res
);
  import rfcd_pkg::*;

  // Pointer range: line skip plus up to 255 lines, plus one line's worth of
  // segments (255 x (skip 255 + run 128)). Always wider than 16 bits.
  localparam int unsigned AW =
    $clog2((FRAME_HEIGHT + 256) * LINE_WIDTH + 256 * 384 + 256);
  localparam logic [AW:0]   FRAME_PIX = (AW+1)'(LINE_WIDTH * FRAME_HEIGHT);
  localparam logic [AW-1:0] LW        = AW'(LINE_WIDTH);
  localparam logic [15:0]   FH16      = 16'(FRAME_HEIGHT);
  localparam logic [7:0]    FH8       = 8'(FRAME_HEIGHT);

  logic [7:0]    key_height;
  phase_t        phase, phase_next;
  logic [AW-1:0] line_start, line_start_next;
  logic [AW-1:0] write_pointer, write_pointer_next;
  logic [7:0]    lines_left, lines_left_next;
  logic [7:0]    segments_left, segments_left_next;
  logic [7:0]    run_left, run_left_next;
  logic          run_is_fill, run_is_fill_next;
  logic [7:0]    header_low, header_low_next;
  logic          delta_mode, delta_mode_next;

  // Key height register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_height <= 8'(KEY_HEIGHT_RESET);
    end else if (cfg_wen) begin
      key_height <= cfg_wdata;
    end
  end

  // Parse one byte
  always_comb begin
    logic [7:0]    b;
    logic [15:0]   word;
    logic [7:0]    skip;
    logic          neg;
    logic          literal;
    logic          seg_done;
    logic          line_done;
    logic          ended;
    logic          wr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_run;

    b                  = item.data_byte;
    word               = {b, header_low};
    skip               = 8'd0;
    neg                = b[7];
    literal            = 1'b0;
    seg_done           = 1'b0;
    line_done          = 1'b0;
    ended              = 1'b0;
    wr                 = 1'b0;
    wr_addr            = write_pointer;
    wr_run             = 8'd0;
    phase_next         = phase;
    line_start_next    = line_start;
    write_pointer_next = write_pointer;
    lines_left_next    = lines_left;
    segments_left_next = segments_left;
    run_left_next      = run_left;
    run_is_fill_next   = run_is_fill;
    header_low_next    = header_low;
    delta_mode_next    = delta_mode;
    res_valid          = 1'b0;
    res                = '0;

    // A chunk start abandons whatever was in progress
    if (item.chunk_start) begin
      delta_mode_next    = item.delta_chunk;
      line_start_next    = '0;
      write_pointer_next = '0;
      segments_left_next = 8'd0;
      run_left_next      = 8'd0;
      run_is_fill_next   = 1'b0;
      if (item.delta_chunk) begin
        lines_left_next = 8'd0;
        phase_next      = PH_SKIP_LO;
      end else begin
        lines_left_next = (key_height == 8'd0) ? 8'd1 : key_height;
        phase_next      = PH_SEGCOUNT;
      end
    end

    case (phase_next)
      PH_SKIP_LO: begin
        header_low_next = b;
        phase_next      = PH_SKIP_HI;
      end
      PH_SKIP_HI: begin
        skip               = (word > FH16) ? FH8 : word[7:0];
        line_start_next    = AW'(skip) * LW;
        write_pointer_next = AW'(skip) * LW;
        phase_next         = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        header_low_next = b;
        phase_next      = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        if (word[15] || word == 16'd0) begin
          lines_left_next = 8'd1;
        end else if (word > FH16) begin
          lines_left_next = FH8;
        end else begin
          lines_left_next = word[7:0];
        end
        phase_next = PH_SEGCOUNT;
      end
      PH_SEGCOUNT: begin
        if (b == 8'd0) begin
          line_done = 1'b1;
        end else begin
          segments_left_next = b;
          phase_next         = delta_mode_next ? PH_PIXSKIP : PH_SEGHEAD;
        end
      end
      PH_PIXSKIP: begin
        write_pointer_next = write_pointer_next + AW'(b);
        phase_next         = PH_SEGHEAD;
      end
      PH_SEGHEAD: begin
        // Sign of the head byte picks literal or fill, swapped in delta
        literal          = delta_mode_next ? (!neg && b != 8'd0) : neg;
        run_is_fill_next = !literal;
        if (neg) begin
          run_left_next = 8'd0 - b;
        end else if (!literal && delta_mode_next) begin
          run_left_next = 8'd0;
        end else begin
          run_left_next = b;
        end
        phase_next = PH_RUN;
      end
      PH_RUN: begin
        wr_addr = write_pointer_next;
        if (run_is_fill_next) begin
          wr_run             = run_left_next;
          write_pointer_next = write_pointer_next + AW'(run_left_next);
          run_left_next      = 8'd0;
          seg_done           = 1'b1;
        end else begin
          wr_run             = 8'd1;
          write_pointer_next = write_pointer_next + AW'(1);
          run_left_next      = run_left_next - 8'd1;
          seg_done           = (run_left_next == 8'd0);
        end
        wr = (wr_run != 8'd0);
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // End of segment
    if (seg_done) begin
      segments_left_next = segments_left_next - 8'd1;
      if (segments_left_next == 8'd0) begin
        line_done = 1'b1;
      end else begin
        phase_next = delta_mode_next ? PH_PIXSKIP : PH_SEGHEAD;
      end
    end

    // End of line, and of chunk on the last line
    if (line_done) begin
      lines_left_next    = lines_left_next - 8'd1;
      line_start_next    = line_start_next + LW;
      write_pointer_next = line_start_next;
      if (lines_left_next == 8'd0) begin
        phase_next = PH_IDLE;
        ended      = 1'b1;
      end else begin
        phase_next = PH_SEGCOUNT;
      end
    end

    // Result: a write, or a bare end marker
    if (wr) begin
      res_valid = 1'b1;
      res.write_address = (wr_addr[AW-1:16] != '0) ? ADDR_MAX : wr_addr[15:0];
      res.pixel_value   = b;
      res.run_length    = wr_run;
      res.beyond_frame  = ({1'b0, wr_addr} + (AW+1)'(wr_run)) > FRAME_PIX;
      res.chunk_end     = ended;
    end else if (ended) begin
      res_valid     = 1'b1;
      res.chunk_end = 1'b1;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      line_start    <= '0;
      write_pointer <= '0;
      lines_left    <= 8'd0;
      segments_left <= 8'd0;
      run_left      <= 8'd0;
      run_is_fill   <= 1'b0;
      header_low    <= 8'd0;
      delta_mode    <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      line_start    <= line_start_next;
      write_pointer <= write_pointer_next;
      lines_left    <= lines_left_next;
      segments_left <= segments_left_next;
      run_left      <= run_left_next;
      run_is_fill   <= run_is_fill_next;
      header_low    <= header_low_next;
      delta_mode    <= delta_mode_next;
    end
  end

endmodule

// ===== hdl/rfcd_out_reg.sv =====
module rfcd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  rfcd_pkg::result_t load_res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output rfcd_pkg::result_t out_res
);
  import rfcd_pkg::*;

  // Takes a new result when empty or when the current one leaves this cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_res <= load_res;
    end
  end

endmodule

// ===== test/frame_write_checker.sv =====
module frame_write_checker #(
  parameter int unsigned LINE_WIDTH   = 320,
  parameter int unsigned FRAME_HEIGHT = 200
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import rfcd_pkg::*;

  localparam int unsigned FRAME_PIXELS = LINE_WIDTH * FRAME_HEIGHT;

  // Own copy of the parser state and the key height register
  phase_t      ph;
  logic [31:0] line_base;
  logic [31:0] wptr;
  logic [7:0]  lines_left;
  logic [7:0]  segs_left;
  logic [7:0]  run_left;
  logic [7:0]  hdr_lo;
  logic [7:0]  height;
  logic        fill_run;
  logic        delta_fmt;

  result_t writes_due[$];
  int      err_count = 0;
  int      seen = 0;

  task automatic report(input string msg);
    err_count++;
    // keep the log short if something goes badly wrong
    if (err_count <= 30) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) begin
      report($sformatf("result %0d: %s is %0d, expected %0d", seen, name, got, want));
    end
  endtask

  function automatic void add_write(input logic [31:0] addr, input logic [7:0] pix,
                                    input logic [7:0] run, input logic last);
    result_t r;
    r.write_address = (addr > 32'hFFFF) ? ADDR_MAX : addr[15:0];
    r.pixel_value   = pix;
    r.run_length    = run;
    r.beyond_frame  = (addr + run > FRAME_PIXELS);
    r.chunk_end     = last;
    writes_due.push_back(r);
  endfunction

  // Step to the next line; 1 when the chunk is complete
  function automatic logic close_line();
    lines_left = lines_left - 8'd1;
    line_base  = line_base + LINE_WIDTH;
    wptr       = line_base;
    if (lines_left == 8'd0) begin
      ph = PH_IDLE;
      return 1'b1;
    end
    ph = PH_SEGCOUNT;
    return 1'b0;
  endfunction

  function automatic logic close_segment();
    segs_left = segs_left - 8'd1;
    if (segs_left == 8'd0) begin
      return close_line();
    end
    ph = delta_fmt ? PH_PIXSKIP : PH_SEGHEAD;
    return 1'b0;
  endfunction

  // Expected frame-buffer write (if any) for one accepted chunk byte
  function automatic void decode_byte(input logic [7:0] b, input logic st, input logic dl);
    logic        done;
    logic [31:0] val;
    logic [31:0] addr;
    logic [7:0]  run;
    logic        lit;
    done = 1'b0;
    if (st) begin
      delta_fmt = dl;
      line_base = '0;
      wptr      = '0;
      segs_left = '0;
      run_left  = '0;
      fill_run  = 1'b0;
      if (dl) begin
        lines_left = '0;
        ph = PH_SKIP_LO;
      end else begin
        lines_left = (height == 8'd0) ? 8'd1 : height;
        ph = PH_SEGCOUNT;
      end
    end
    case (ph)
      PH_SKIP_LO, PH_CNT_LO: begin
        hdr_lo = b;
        ph = (ph == PH_SKIP_LO) ? PH_SKIP_HI : PH_CNT_HI;
      end
      PH_SKIP_HI: begin
        val = {16'd0, b, hdr_lo};
        if (val > FRAME_HEIGHT) val = FRAME_HEIGHT;
        line_base = val * LINE_WIDTH;
        wptr = line_base;
        ph = PH_CNT_LO;
      end
      PH_CNT_HI: begin
        // signed line count, saturated to 1..FRAME_HEIGHT
        val = {16'd0, b, hdr_lo};
        if (val[15] || val == 0) lines_left = 8'd1;
        else if (val > FRAME_HEIGHT) lines_left = 8'(FRAME_HEIGHT);
        else lines_left = val[7:0];
        ph = PH_SEGCOUNT;
      end
      PH_SEGCOUNT: begin
        if (b == 8'd0) begin
          done = close_line();
        end else begin
          segs_left = b;
          ph = delta_fmt ? PH_PIXSKIP : PH_SEGHEAD;
        end
      end
      PH_PIXSKIP: begin
        wptr = wptr + b;
        ph = PH_SEGHEAD;
      end
      PH_SEGHEAD: begin
        // literal and fill signs are swapped between key and delta
        lit = delta_fmt ? (!b[7] && b != 8'd0) : b[7];
        fill_run = !lit;
        run_left = b[7] ? 8'd0 - b : b;
        ph = PH_RUN;
      end
      PH_RUN: begin
        addr = wptr;
        if (fill_run) begin
          run = run_left;
          run_left = '0;
        end else begin
          run = 8'd1;
          run_left = run_left - 8'd1;
        end
        wptr = wptr + run;
        if (fill_run || run_left == 8'd0) done = close_segment();
        if (run != 8'd0) begin
          add_write(addr, b, run, done);
          done = 1'b0;
        end
      end
      default: ph = PH_IDLE;
    endcase
    // chunk ended on a byte without a write: end marker only
    if (done) add_write('0, '0, '0, 1'b1);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      ph         = PH_IDLE;
      line_base  = '0;
      wptr       = '0;
      lines_left = '0;
      segs_left  = '0;
      run_left   = '0;
      hdr_lo     = '0;
      fill_run   = 1'b0;
      delta_fmt  = 1'b0;
      height     = 8'(KEY_HEIGHT_RESET);
      writes_due.delete();
    end else begin
      if (cfg_wen) height = cfg_wdata;
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser[0], s_tuser[1]);
      if (m_tvalid && m_tready) begin
        got = {m_tlast, m_tuser, m_tdata};
        seen++;
        if (writes_due.size() == 0) begin
          report($sformatf("result %0d (%h) arrived with nothing expected", seen, got));
        end else begin
          want = writes_due.pop_front();
          check_field("write_address", got.write_address, want.write_address);
          check_field("pixel_value", got.pixel_value, want.pixel_value);
          check_field("run_length", got.run_length, want.run_length);
          check_field("beyond_frame", got.beyond_frame, want.beyond_frame);
          check_field("chunk_end", got.chunk_end, want.chunk_end);
        end
      end
    end
    errors       <= err_count;
    pending      <= writes_due.size();
    results_seen <= seen;
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rfcd_pkg::*;

  localparam int unsigned LINE_WIDTH   = 320;
  localparam int unsigned FRAME_HEIGHT = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 180;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wen;
  logic [7:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int errors;
  int pending;
  int results_seen;

  int send_idle_pct = 37;
  int recv_idle_pct = 62;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  int         bytes_sent = 0;
  int         chunks_sent = 0;
  int         chunk_bytes = 0;
  int         cut_at = -1;
  logic       fresh = 1'b0;
  logic       fmt = 1'b0;
  logic [7:0] height_now = 8'(KEY_HEIGHT_RESET);

  always #5 clk = ~clk;

  rle_frame_chunk_decoder #(
    .LINE_WIDTH  (LINE_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  frame_write_checker #(
    .LINE_WIDTH  (LINE_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .pending     (pending),
    .results_seen(results_seen)
  );

  // Receiver: random back-pressure, plus a long hold-off when asked for
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // One request on the slave side, with random gaps in front of it
  task automatic push_byte(input logic [7:0] b, input logic st, input logic dl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 2'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {dl, st};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Byte of the current chunk; the first one carries chunk_start and the format
  task automatic put(input logic [7:0] b);
    if (chunk_bytes == cut_at) return;
    push_byte(b, fresh, fresh ? fmt : 1'($urandom));
    fresh = 1'b0;
    chunk_bytes++;
    bytes_sent++;
  endtask

  // Mostly well-formed chunk with random content; some cut short or pure noise
  task automatic gen_chunk();
    logic [15:0] w;
    logic [7:0]  head;
    int          lines;
    int          segs;
    int          n;
    logic        lit;
    fresh = 1'b1;
    fmt = 1'($urandom);
    chunk_bytes = 0;
    chunks_sent++;
    cut_at = ($urandom_range(11) == 0) ? $urandom_range(12, 1) : -1;
    if ($urandom_range(15) == 0) begin
      repeat ($urandom_range(8, 1)) put(8'($urandom));
      return;
    end
    if (fmt) begin
      case ($urandom_range(9))
        0:       w = 16'($urandom);
        1:       w = 16'(FRAME_HEIGHT + $urandom_range(1));
        default: w = 16'($urandom_range(4));
      endcase
      put(w[7:0]);
      put(w[15:8]);
      case ($urandom_range(9))
        0:       w = 16'd0;
        1:       w = 16'h8000 | 16'($urandom);
        2:       w = 16'($urandom_range(32767, FRAME_HEIGHT + 1));
        3:       w = 16'(FRAME_HEIGHT);
        default: w = 16'($urandom_range(3, 1));
      endcase
      put(w[7:0]);
      put(w[15:8]);
      lines = (w[15] || w == 16'd0) ? 1 : ((w > FRAME_HEIGHT) ? FRAME_HEIGHT : int'(w));
    end else begin
      lines = (height_now == 8'd0) ? 1 : int'(height_now);
    end
    // tall chunks are left open and abandoned by the next chunk start
    if (lines > 4) lines = $urandom_range(4, 1);
    for (int l = 0; l < lines; l++) begin
      segs = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1);
      if ($urandom_range(39) == 0) segs = $urandom_range(255, 4);
      put(8'(segs));
      for (int s = 0; s < segs && s < 4; s++) begin
        if (fmt) put(($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(8)));
        lit = 1'($urandom);
        if (lit) begin
          n = ($urandom_range(19) == 0) ? $urandom_range(128 - int'(fmt), 1) : $urandom_range(3, 1);
        end else begin
          n = ($urandom_range(7) == 0) ? 0 : $urandom_range(127 + int'(fmt), 1);
        end
        head = (lit ^ fmt) ? 8'(256 - n) : 8'(n);
        put(head);
        if (lit) begin
          repeat (n) put(8'($urandom));
        end else begin
          put(8'($urandom));
        end
      end
      if (segs > 4) return;
    end
    // stray bytes after the chunk
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(3, 1)) push_byte(8'($urandom), 1'b0, 1'($urandom));
    end
  endtask

  task automatic set_height(input logic [7:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    height_now = v;
  endtask

  // Let every expected write drain, then give the pipeline time to empty
  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] height, input int tx_idle, input int rx_idle,
                           input logic squeeze);
    int goal;
    settle();
    set_height(height);
    send_idle_pct = tx_idle;
    recv_idle_pct <= rx_idle;
    if (squeeze) hold_reqs <= hold_reqs + 1;
    goal = bytes_sent + PHASE_BYTES;
    while (bytes_sent < goal) gen_chunk();
  endtask

  initial begin
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_height(8'd2);

    // Directed: stray byte before any chunk
    push_byte(8'hFF, 1'b0, 1'b1);
    // key: one literal, a 127 fill, then a zero-length fill closing the chunk
    fresh = 1'b1;
    fmt = 1'b0;
    put(8'h02); put(8'hFF); put(8'h00); put(8'h7F); put(8'hFF);
    put(8'h01); put(8'h00); put(8'hAB);
    push_byte(8'h55, 1'b0, 1'b0);
    // delta: oversized line skip, five empty lines, 128 fill past address 65535
    fresh = 1'b1;
    fmt = 1'b1;
    put(8'hFF); put(8'hFF); put(8'h08); put(8'h00);
    repeat (5) put(8'h00);
    put(8'h01); put(8'hFF); put(8'h80); put(8'h5A);
    // key chunk breaks in mid-chunk: two empty lines, end marker
    fresh = 1'b1;
    fmt = 1'b0;
    put(8'h00); put(8'h00);

    run_phase(8'd1, 37, 62, 1'b1);
    run_phase(8'd0, 37, 62, 1'b0);
    run_phase(8'd3, 62, 37, 1'b0);
    run_phase(8'd255, 62, 37, 1'b0);
    run_phase(8'd200, 0, 0, 1'b0);
    settle();

    $display("Run covered %0d chunk bytes in %0d random chunks after a directed set,",
             bytes_sent, chunks_sent);
    $display("checking %0d writes and end markers at key heights 0, 1, 2, 3, 200 and 255.",
             results_seen);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== rle_frame_chunk_decoder.f =====
hdl/rfcd_pkg.sv
hdl/rfcd_in_reg.sv
hdl/rfcd_parser.sv
hdl/rfcd_out_reg.sv
hdl/rle_frame_chunk_decoder.sv
test/frame_write_checker.sv
test/testbench.sv
